FILE: rtl/assert_macros.svh
// Assertion macros for the RTL of the process table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// The condition must hold at every clock edge outside reset.
`define PST7_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define PST7_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PST7_ASSERT_ALWAYS(lbl, cond, msg)
`define PST7_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/pst7_pkg.sv
// Package with the types, codes and transition tables of the process table.
package pst7_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 16;

  localparam logic [3:0] REQ_CREATE     = 4'd0;
  localparam logic [3:0] REQ_LAST_EVENT = 4'd12;

  typedef enum logic [2:0] {
    ST_NEW        = 3'd0,
    ST_READY      = 3'd1,
    ST_RUNNING    = 3'd2,
    ST_WAITING    = 3'd3,
    ST_SUSP_READY = 3'd4,
    ST_SUSP_WAIT  = 3'd5,
    ST_TERMINATED = 3'd6
  } proc_state_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_INVALID   = 2'd3
  } status_t;

  typedef struct packed {
    proc_state_t st;
    logic [3:0]  prio;
    logic [15:0] burst;
  } entry_t;

  function automatic proc_state_t ev_src(input logic [3:0] req);
    proc_state_t s;
    case (req)
      4'd1:    s = ST_NEW;
      4'd2:    s = ST_READY;
      4'd3:    s = ST_RUNNING;
      4'd4:    s = ST_RUNNING;
      4'd5:    s = ST_WAITING;
      4'd6:    s = ST_RUNNING;
      4'd7:    s = ST_READY;
      4'd8:    s = ST_SUSP_READY;
      4'd9:    s = ST_WAITING;
      4'd10:   s = ST_SUSP_WAIT;
      4'd11:   s = ST_SUSP_WAIT;
      4'd12:   s = ST_RUNNING;
      default: s = ST_NEW;
    endcase
    return s;
  endfunction

  function automatic proc_state_t ev_dst(input logic [3:0] req);
    proc_state_t s;
    case (req)
      4'd1:    s = ST_READY;
      4'd2:    s = ST_RUNNING;
      4'd3:    s = ST_READY;
      4'd4:    s = ST_WAITING;
      4'd5:    s = ST_READY;
      4'd6:    s = ST_TERMINATED;
      4'd7:    s = ST_SUSP_READY;
      4'd8:    s = ST_READY;
      4'd9:    s = ST_SUSP_WAIT;
      4'd10:   s = ST_SUSP_READY;
      4'd11:   s = ST_WAITING;
      4'd12:   s = ST_SUSP_READY;
      default: s = ST_NEW;
    endcase
    return s;
  endfunction

  function automatic logic is_suspended(input proc_state_t s);
    return (s == ST_SUSP_READY) || (s == ST_SUSP_WAIT);
  endfunction

endpackage

FILE: rtl/pst7_if.sv
// Valid/ready channel interfaces for requests and results of the process table.
interface pst7_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  req_type;
  logic [4:0]  proc_id;
  logic [3:0]  prio_in;
  logic [15:0] burst_in;

  modport source(output valid, req_type, proc_id, prio_in, burst_in, input ready);
  modport sink(input valid, req_type, proc_id, prio_in, burst_in, output ready);
endinterface

interface pst7_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [4:0]  pid_out;
  logic [2:0]  old_state;
  logic [2:0]  new_state;
  logic        to_disk;
  logic        to_memory;
  logic [3:0]  prio_out;
  logic [15:0] burst_out;

  modport source(output valid, status, pid_out, old_state, new_state, to_disk, to_memory,
                 prio_out, burst_out, input ready);
  modport sink(input valid, status, pid_out, old_state, new_state, to_disk, to_memory,
               prio_out, burst_out, output ready);
endinterface

FILE: rtl/pst7_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module pst7_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/process_state_table_7state.sv
// Top level of the seven-state process table.
//
// Requests arrive on the request channel (valid/ready, one transfer per item)
// and each one gives exactly one transfer on the result channel. A create
// request takes the next free slot and answers with its identifier; an
// event request looks up the slot of its identifier, checks the source
// state and moves the process to the target state.
// The table entries live in a RAM with a registered read port. A request is
// read from the RAM in the cycle it is taken and held in the request stage;
// it is resolved once the result register can take it, where the entry is
// written back and the result is registered. A request can be taken in
// every cycle while the receiver does not stall; a write-back that the
// following request's read missed is forwarded from a holding register.
// Reset empties the table: the slot count returns to zero and both channels
// go idle. The RAM itself is not cleared. When the receiver stalls, the
// result register holds its item and the pending request waits behind it;
// one more request is taken only if the request stage is empty or the
// result register frees up.
module process_state_table_7state #(
  parameter int unsigned TABLE_DEPTH = pst7_pkg::TABLE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  pst7_req_if.sink   request,
  pst7_rsp_if.source result
);
  import pst7_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned UW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned WIDTH_E = $bits(entry_t);

  logic              s1_valid;
  logic [3:0]        s1_req;
  logic [4:0]        s1_pid;
  logic [3:0]        s1_prio;
  logic [15:0]       s1_burst;
  logic [AW-1:0]     s1_addr;
  logic [UW-1:0]     used_slots;
  logic [UW-1:0]     used_slots_next;
  logic              fwd_valid;
  logic [AW-1:0]     fwd_addr;
  entry_t            fwd_data;

  logic              res_valid;
  status_t           res_status;
  logic [4:0]        res_pid;
  proc_state_t       res_old;
  proc_state_t       res_new;
  logic              res_disk;
  logic              res_mem;
  logic [3:0]        res_prio;
  logic [15:0]       res_burst;

  status_t           status_next;
  logic [4:0]        pid_next;
  proc_state_t       old_next;
  proc_state_t       new_next;
  logic              disk_next;
  logic              mem_next;
  logic [3:0]        prio_next;
  logic [15:0]       burst_next;

  logic              accept;
  logic              s1_adv;
  logic [8:0]        rd_slot;
  logic [WIDTH_E-1:0] ram_rdata;
  entry_t            ent;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  entry_t            ram_wdata;
  logic              create_ok;
  logic [8:0]        used_ext;
  proc_state_t       src_st;
  proc_state_t       dst_st;

  assign s1_adv        = s1_valid && (!res_valid || result.ready);
  assign request.ready = !s1_valid || s1_adv;
  assign accept        = request.valid && request.ready;
  assign rd_slot       = {4'd0, request.proc_id} - 9'd1;

  pst7_ram #(
    .WIDTH (WIDTH_E),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (rd_slot[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign ent      = (fwd_valid && (fwd_addr == s1_addr)) ? fwd_data : entry_t'(ram_rdata);
  assign used_ext = 9'(used_slots);
  assign src_st   = ev_src(s1_req);
  assign dst_st   = ev_dst(s1_req);

  always_comb begin
    status_next     = STAT_OK;
    pid_next        = 5'd0;
    old_next        = ST_NEW;
    new_next        = ST_NEW;
    disk_next       = 1'b0;
    mem_next        = 1'b0;
    prio_next       = 4'd0;
    burst_next      = 16'd0;
    ram_we          = 1'b0;
    ram_waddr       = s1_addr;
    ram_wdata       = ent;
    create_ok       = 1'b0;
    used_slots_next = used_slots;
    if (s1_req == REQ_CREATE) begin
      if (used_slots == UW'(TABLE_DEPTH)) begin
        status_next = STAT_FULL;
      end else begin
        create_ok       = 1'b1;
        pid_next        = 5'(used_ext + 9'd1);
        prio_next       = s1_prio;
        burst_next      = s1_burst;
        ram_we          = s1_adv;
        ram_waddr       = used_slots[AW-1:0];
        ram_wdata       = '{st: ST_NEW, prio: s1_prio, burst: s1_burst};
        used_slots_next = UW'(used_ext + 9'd1);
      end
    end else if (s1_req > REQ_LAST_EVENT) begin
      status_next = STAT_INVALID;
    end else if ((s1_pid == 5'd0) || ({4'd0, s1_pid} > used_ext)) begin
      status_next = STAT_NOT_FOUND;
    end else begin
      pid_next   = s1_pid;
      old_next   = ent.st;
      prio_next  = ent.prio;
      burst_next = ent.burst;
      if (ent.st != src_st) begin
        status_next = STAT_INVALID;
        new_next    = ent.st;
      end else begin
        new_next  = dst_st;
        disk_next = is_suspended(dst_st);
        mem_next  = is_suspended(src_st);
        ram_we    = s1_adv;
        ram_wdata = '{st: dst_st, prio: ent.prio, burst: ent.burst};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      res_valid  <= 1'b0;
      fwd_valid  <= 1'b0;
      used_slots <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        res_valid  <= 1'b1;
        used_slots <= used_slots_next;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      if (ram_we) begin
        fwd_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req   <= request.req_type;
      s1_pid   <= request.proc_id;
      s1_prio  <= request.prio_in;
      s1_burst <= request.burst_in;
      s1_addr  <= rd_slot[AW-1:0];
    end
    if (ram_we) begin
      fwd_addr <= ram_waddr;
      fwd_data <= ram_wdata;
    end
    if (s1_adv) begin
      res_status <= status_next;
      res_pid    <= pid_next;
      res_old    <= old_next;
      res_new    <= new_next;
      res_disk   <= disk_next;
      res_mem    <= mem_next;
      res_prio   <= prio_next;
      res_burst  <= burst_next;
    end
  end

  assign result.valid     = res_valid;
  assign result.status    = res_status;
  assign result.pid_out   = res_pid;
  assign result.old_state = res_old;
  assign result.new_state = res_new;
  assign result.to_disk   = res_disk;
  assign result.to_memory = res_mem;
  assign result.prio_out  = res_prio;
  assign result.burst_out = res_burst;

`include "assert_macros.svh"

  `PST7_ASSERT_ALWAYS(a_used_in_range, (used_slots <= UW'(TABLE_DEPTH)), "slot count beyond table depth")
  `PST7_ASSERT_ALWAYS(a_full_only_when_full, (!(res_valid && (res_status == STAT_FULL)) || (used_slots == UW'(TABLE_DEPTH))), "table full reported while slots remain")
  `PST7_ASSERT_NEXT(a_count_steady, (!(s1_adv && create_ok)), $stable(used_slots), "slot count changed without a create")

endmodule
